@@ rtl/core/rsc_pkg.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared widths, command codes, status codes and the arithmetic unit interface.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int WORD_W              = 32;
    localparam int MODE_W              = 3;
    localparam int DEPTH_OUT_W         = 5;
    localparam int STATUS_W            = 2;
    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int ITER_W              = $clog2(WORD_W);

    localparam int IN_DATA_W  = ((MODE_W + WORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((WORD_W + DEPTH_OUT_W + STATUS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_SUB    = 3'd2,
        MODE_MUL    = 3'd3,
        MODE_DIV    = 3'd4,
        MODE_FINISH = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_UNDER    = 2'd1,
        STAT_OVERFLOW = 2'd2,
        STAT_DIVZERO  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

endpackage

@@ rtl/core/rsc_alu.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator serial arithmetic unit
// Computes b op a one bit per cycle: ripple-serial add and subtract, radix-2
// shift-add multiply and radix-2 restoring divide on magnitudes.
// ----------------------------------------------------------------------------
module rsc_alu (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rsc_pkg::alu_req_t        req,
    input  logic [rsc_pkg::WORD_W-1:0] a_val,
    input  logic [rsc_pkg::WORD_W-1:0] b_val,
    output rsc_pkg::alu_rsp_t        rsp
);
    import rsc_pkg::*;

    typedef enum logic [2:0] {
        AS_IDLE = 3'b001,
        AS_RUN  = 3'b010,
        AS_FIN  = 3'b100
    } alu_state_t;

    alu_state_t          state_reg, state_next;
    alu_op_t             op_reg, op_next;
    logic [WORD_W-1:0]   x_reg, x_next;
    logic [WORD_W-1:0]   y_reg, y_next;
    logic [WORD_W:0]     acc_reg, acc_next;
    logic                carry_reg, carry_next;
    logic                neg_reg, neg_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic                done_reg, done_next;
    logic [WORD_W-1:0]   result_reg, result_next;

    logic                sum_bit;
    logic [WORD_W:0]     rem_shift;
    logic [WORD_W+1:0]   rem_diff;
    logic                q_bit;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        carry_next  = carry_reg;
        neg_next    = neg_reg;
        iter_next   = iter_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        sum_bit   = x_reg[0] ^ y_reg[0] ^ carry_reg;
        rem_shift = {acc_reg[WORD_W-1:0], x_reg[WORD_W-1]};
        rem_diff  = {1'b0, rem_shift} - {2'b00, y_reg};
        q_bit     = ~rem_diff[WORD_W+1];

        case (state_reg)
            AS_IDLE: begin
                if (req.start) begin
                    op_next    = req.op;
                    iter_next  = '0;
                    acc_next   = '0;
                    carry_next = 1'b0;
                    neg_next   = 1'b0;
                    x_next     = b_val;
                    y_next     = a_val;
                    state_next = AS_RUN;
                    case (req.op)
                        ALU_SUB: begin
                            y_next     = ~a_val;
                            carry_next = 1'b1;
                        end
                        ALU_DIV: begin
                            x_next   = b_val[WORD_W-1] ? -b_val : b_val;
                            y_next   = a_val[WORD_W-1] ? -a_val : a_val;
                            neg_next = b_val[WORD_W-1] ^ a_val[WORD_W-1];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            AS_RUN: begin
                case (op_reg)
                    ALU_ADD, ALU_SUB: begin
                        carry_next = (x_reg[0] & y_reg[0]) | (carry_reg & (x_reg[0] ^ y_reg[0]));
                        x_next     = x_reg >> 1;
                        y_next     = y_reg >> 1;
                        acc_next   = {1'b0, sum_bit, acc_reg[WORD_W-1:1]};
                    end
                    ALU_MUL: begin
                        acc_next = {1'b0, acc_reg[WORD_W-1:0] + (y_reg[0] ? x_reg : '0)};
                        x_next   = x_reg << 1;
                        y_next   = y_reg >> 1;
                    end
                    default: begin
                        acc_next = q_bit ? rem_diff[WORD_W:0] : rem_shift;
                        x_next   = {x_reg[WORD_W-2:0], q_bit};
                    end
                endcase
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(WORD_W - 1)) begin
                    state_next = AS_FIN;
                end
            end
            AS_FIN: begin
                // The quotient takes its sign here; the other results are ready.
                if (op_reg == ALU_DIV) begin
                    result_next = neg_reg ? -x_reg : x_reg;
                end else begin
                    result_next = acc_reg[WORD_W-1:0];
                end
                done_next  = 1'b1;
                state_next = AS_IDLE;
            end
            default: begin
                state_next = AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        op_reg     <= op_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        carry_reg  <= carry_next;
        neg_reg    <= neg_next;
        iter_reg   <= iter_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

@@ rtl/core/rpn_stack_calculator_unit.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator unit
// Reverse Polish calculator on a stack of signed 32-bit words.
// ----------------------------------------------------------------------------
// Each item on the slave channel is one command: s_tdata carries the mode in
// bits 2:0 and the operand in bits 34:3. Every command gives exactly one item
// on the master channel with the top value, the stack depth and a status code.
// The block works on one command at a time. A push, a finish or an unused mode
// is carried out in the execute state, and its result is loaded into the output
// register from the respond state. Add, subtract, multiply and divide go
// through a bit-serial arithmetic unit that takes 32 steps plus a final step,
// and their result is pushed once the unit reports done. The next command is
// taken once the result has moved on from the respond state.
// The stack lives in a memory with a registered read port; the word below the
// top is read while the command waits and the top itself sits in a register.
// Reset empties the stack at once by clearing the entry count; the memory is
// not swept. While reset is held s_tready and m_tvalid are low.
// A result waits in the output register while the receiver stalls. The next
// command is still accepted and processed, and its result waits inside the
// block until the output register is free.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = rsc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata fields from bit 0: mode (3), operand_value (32), zero fill (5)
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rsc_pkg::IN_DATA_W-1:0]  s_tdata,
    // m_tdata fields from bit 0: top_value (32), stack_depth (5), status (2),
    // zero fill (1)
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rsc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rsc_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int PAD_W  = OUT_DATA_W - WORD_W - DEPTH_OUT_W - STATUS_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_CALC = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    // Stack storage. Only values of entries below the count are ever used.
    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

    state_t                 state_reg, state_next;
    logic                   ready_reg, ready_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [WORD_W-1:0]      opnd_reg, opnd_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [WORD_W-1:0]      top_reg, top_next;
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   under_reg, under_next;
    logic                   dz_reg, dz_next;
    logic [WORD_W-1:0]      res_top_reg, res_top_next;
    logic [CNT_W-1:0]       res_cnt_reg, res_cnt_next;
    status_t                res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                   accept;
    logic                   has_top;
    logic                   has_two;
    logic [WORD_W-1:0]      a_val;
    logic [WORD_W-1:0]      b_val;
    logic [WORD_W-1:0]      calc_result;
    logic [CNT_W-1:0]       below_two;
    logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [WORD_W-1:0]      mem_wdata;

    alu_req_t               alu_req;
    alu_rsp_t               alu_rsp;

    rsc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a_val   (a_val),
        .b_val   (b_val),
        .rsp     (alu_rsp)
    );

    assign accept    = s_tvalid && ready_reg;
    assign has_top   = (count_reg != '0);
    assign has_two   = (count_reg >= CNT_W'(2));
    assign below_two = count_reg - CNT_W'(2);

    // An operand missing from the stack reads as zero.
    assign a_val = has_top ? top_reg : '0;
    assign b_val = has_two ? rd_data_reg : '0;

    // A divide by zero pushes zero whatever the divider returns.
    assign calc_result = dz_reg ? '0 : alu_rsp.result;

    assign depth_ext = {{DEPTH_OUT_W{1'b0}}, res_cnt_reg};

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        opnd_next       = opnd_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        under_next      = under_reg;
        dz_next         = dz_reg;
        res_top_next    = res_top_reg;
        res_cnt_next    = res_cnt_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        mem_wdata       = opnd_reg;
        alu_req.start   = 1'b0;
        alu_req.op      = ALU_ADD;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next  = s_tdata[MODE_W-1:0];
                    opnd_next  = s_tdata[MODE_W+WORD_W-1:MODE_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The word below the top was read while the command waited.
                state_next      = ST_RESP;
                res_top_next    = a_val;
                res_cnt_next    = count_reg;
                res_status_next = STAT_OK;
                case (mode_reg)
                    MODE_PUSH: begin
                        if (count_reg < CNT_W'(STACK_DEPTH)) begin
                            mem_we       = 1'b1;
                            top_next     = opnd_reg;
                            count_next   = count_reg + CNT_W'(1);
                            res_top_next = opnd_reg;
                            res_cnt_next = count_reg + CNT_W'(1);
                        end else begin
                            res_status_next = STAT_OVERFLOW;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                        alu_req.start = 1'b1;
                        case (mode_reg)
                            MODE_ADD: alu_req.op = ALU_ADD;
                            MODE_SUB: alu_req.op = ALU_SUB;
                            MODE_MUL: alu_req.op = ALU_MUL;
                            default:  alu_req.op = ALU_DIV;
                        endcase
                        under_next = !has_two;
                        dz_next    = (mode_reg == MODE_DIV) && (a_val == '0);
                        count_next = has_two ? below_two : '0;
                        state_next = ST_CALC;
                    end
                    MODE_FINISH: begin
                        if (has_top) begin
                            count_next   = count_reg - CNT_W'(1);
                            top_next     = rd_data_reg;
                            res_cnt_next = count_reg - CNT_W'(1);
                        end else begin
                            res_status_next = STAT_UNDER;
                        end
                    end
                    default: begin
                        // Unused modes leave the stack alone and report the top.
                    end
                endcase
            end
            ST_CALC: begin
                if (alu_rsp.done) begin
                    mem_we       = 1'b1;
                    mem_wdata    = calc_result;
                    top_next     = calc_result;
                    count_next   = count_reg + CNT_W'(1);
                    res_top_next = calc_result;
                    res_cnt_next = count_reg + CNT_W'(1);
                    if (under_reg) begin
                        res_status_next = STAT_UNDER;
                    end else if (dz_reg) begin
                        res_status_next = STAT_DIVZERO;
                    end else begin
                        res_status_next = STAT_OK;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_W{1'b0}}, res_status_reg,
                                      depth_ext[DEPTH_OUT_W-1:0], res_top_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        mode_reg       <= mode_next;
        opnd_reg       <= opnd_next;
        top_reg        <= top_next;
        under_reg      <= under_next;
        dz_reg         <= dz_next;
        res_top_reg    <= res_top_next;
        res_cnt_reg    <= res_cnt_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    // Stack memory: one write port and one registered read port that always
    // looks at the entry just below the top.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[below_two[ADDR_W-1:0]];
    end

    assign s_tready = ready_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/core/rsc_checker.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator port checker
// Checks the port behavior of the calculator unit over time.
// ----------------------------------------------------------------------------
module rsc_checker #(
    parameter int STACK_DEPTH = rsc_pkg::DEFAULT_STACK_DEPTH
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [rsc_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rsc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rsc_pkg::*;

    localparam logic [DEPTH_OUT_W-1:0] FULL_DEPTH = DEPTH_OUT_W'(STACK_DEPTH);

    logic [WORD_W-1:0]      out_top;
    logic [DEPTH_OUT_W-1:0] out_depth;
    logic [STATUS_W-1:0]    out_status;
    logic                   in_mode_lsb;

    assign out_top     = m_tdata[WORD_W-1:0];
    assign out_depth   = m_tdata[WORD_W+DEPTH_OUT_W-1:WORD_W];
    assign out_status  = m_tdata[WORD_W+DEPTH_OUT_W+STATUS_W-1:WORD_W+DEPTH_OUT_W];
    assign in_mode_lsb = s_tdata[0];

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Commands are taken one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (in_mode_lsb || !in_mode_lsb) |=> !s_tready)
        else $error("command accepted while another is in progress");

    // A dropped push only happens on a full stack.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status == STAT_OVERFLOW) |-> out_depth == FULL_DEPTH)
        else $error("overflow reported on a stack that is not full");

    // A divide by zero pushes zero.
    a_divzero_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_status == STAT_DIVZERO) |-> out_top == '0)
        else $error("divide by zero gave a nonzero value");

endmodule

bind rpn_stack_calculator_unit rsc_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_rsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/rpn_stack_calculator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator unit testbench
// Drives command items through the stack calculator and checks every result
// item against an in-bench model of the stack, with random gaps on both
// channels and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_tb;

    import rsc_pkg::*;

    localparam int STACK_DEPTH  = DEFAULT_STACK_DEPTH;
    localparam int RANDOM_CMDS  = 1470;
    // The receiver stops once for this long after this many commands went in.
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 600;
    // Cycles without any handshake before the run is declared hung. The worst
    // legal quiet spell is the hold-off above plus one arithmetic command.
    localparam int QUIET_LIMIT  = 4000;
    // Extra cycles after the last result, well past the time of one arithmetic command.
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 20;

    // The fields of one command item on s_tdata.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] operand;
    } calc_cmd_t;

    // The fields of one result item on m_tdata.
    typedef struct packed {
        logic [WORD_W-1:0]      top;
        logic [DEPTH_OUT_W-1:0] depth;
        status_t                status;
    } calc_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    rpn_stack_calculator_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Commands waiting to be offered, and the results the stack model says
    // the block owes us, oldest first.
    calc_cmd_t    pending_cmds[$];
    calc_result_t awaited_results[$];

    // Model of the calculator's stack. Only entries below the count are read.
    logic [WORD_W-1:0] model_stack [STACK_DEPTH];
    int                model_count = 0;

    // Depth the stimulus generator believes the stack has, used to shape
    // well-formed command sequences.
    int gen_depth = 0;

    // Handshake counters. Each is written by one process only, with
    // nonblocking assignments, so other processes see a stable value.
    int items_taken  = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    int           errors = 0;
    int           status_hits [4];
    int           peak_depth = 0;
    int           send_gap = 0;
    int           send_calm = 0;
    int           recv_stall = 0;
    int           recv_calm = 0;
    calc_cmd_t    cur_cmd;
    calc_result_t want;
    calc_result_t got;

    // Picks the idle time before the next item: mostly none or short, a few
    // long, and now and then a calm stretch of back-to-back items.
    function automatic int pick_pause(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // Operand values lean on the corners of the signed range and on zero,
    // which makes divide by zero and wrap-around common.
    function automatic logic [WORD_W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return $urandom_range(0, 32) - 16;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_cmd(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] v);
        calc_cmd_t c;
        c.mode    = m;
        c.operand = v;
        pending_cmds.push_back(c);
        case (m)
            MODE_PUSH:   if (gen_depth < STACK_DEPTH) gen_depth++;
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV:
                gen_depth = ((gen_depth >= 2) ? gen_depth - 2 : 0) + 1;
            MODE_FINISH: if (gen_depth > 0) gen_depth--;
            default: ;
        endcase
    endtask

    // Pops one word from the model stack; an empty stack reads as zero.
    function automatic logic [WORD_W-1:0] pop_operand(inout logic under);
        if (model_count == 0) begin
            under = 1'b1;
            return '0;
        end
        model_count--;
        return model_stack[model_count];
    endfunction

    // Applies one command to the model stack and returns the result item the
    // block must produce for it.
    function automatic calc_result_t evaluate_command(input calc_cmd_t c);
        logic [WORD_W-1:0] a, b, r, num_mag, den_mag, quo;
        logic              under;
        logic              div_zero;
        calc_result_t      res;
        under      = 1'b0;
        div_zero   = 1'b0;
        r          = '0;
        res.status = STAT_OK;
        case (c.mode)
            MODE_PUSH: begin
                if (model_count < STACK_DEPTH) begin
                    model_stack[model_count] = c.operand;
                    model_count++;
                end else begin
                    res.status = STAT_OVERFLOW;
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                a = pop_operand(under);
                b = pop_operand(under);
                case (c.mode)
                    MODE_ADD: r = b + a;
                    MODE_SUB: r = b - a;
                    MODE_MUL: r = b * a;
                    default: begin
                        if (a == '0) begin
                            div_zero = 1'b1;
                        end else begin
                            // Divide magnitudes, then fix the sign; this keeps
                            // the most negative value over minus one wrapping.
                            num_mag = b[WORD_W-1] ? -b : b;
                            den_mag = a[WORD_W-1] ? -a : a;
                            quo     = num_mag / den_mag;
                            r       = (b[WORD_W-1] ^ a[WORD_W-1]) ? -quo : quo;
                        end
                    end
                endcase
                // Two pops always leave room for the result.
                model_stack[model_count] = r;
                model_count++;
                if (under) res.status = STAT_UNDER;
                else if (div_zero) res.status = STAT_DIVZERO;
            end
            default: ;
        endcase
        if (c.mode == MODE_FINISH) begin
            res.top = pop_operand(under);
            if (under) res.status = STAT_UNDER;
        end else begin
            res.top = (model_count == 0) ? '0 : model_stack[model_count - 1];
        end
        res.depth = DEPTH_OUT_W'(model_count);
        return res;
    endfunction

    task automatic report_field(input string field, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, exp_v, act_v);
        end
    endtask

    // Sender. Values read here at the clock edge are the ones from before the
    // edge, so an item counts as taken when valid and ready were both high.
    // The model is advanced at that moment, in acceptance order. A new item is
    // loaded only when the channel is empty or the current item just went in,
    // and s_tvalid gets at most one assignment per edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(evaluate_command(cur_cmd));
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0 || pending_cmds.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - MODE_W - WORD_W){1'b0}},
                                 cur_cmd.operand, cur_cmd.mode};
                    send_gap = pick_pause(send_calm);
                end
            end
        end
    end

    // Receiver. Each result item is unpacked and compared field by field with
    // the oldest expectation. Ready drops after some results and, now and
    // then, at random while waiting, so stalls land on every phase of the
    // block's work; the long hold-off is counted in its own process below.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                got.top    = m_tdata[WORD_W-1:0];
                got.depth  = m_tdata[WORD_W +: DEPTH_OUT_W];
                got.status = status_t'(m_tdata[WORD_W + DEPTH_OUT_W +: STATUS_W]);
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    report_field("top_value", $signed(want.top), $signed(got.top));
                    report_field("stack_depth", want.depth, got.depth);
                    report_field("status", want.status, got.status);
                    status_hits[want.status]++;
                    if (want.depth > peak_depth) peak_depth = want.depth;
                end
                recv_stall = pick_pause(recv_calm);
            end else if (m_tready && recv_stall == 0 && $urandom_range(0, 31) == 0) begin
                recv_stall = $urandom_range(1, 8);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (hold_left == 0);
            end
        end
    end

    // One long hold-off on the result channel while the sender keeps
    // offering, so the output register and the internal result both fill and
    // the block has to drop s_tready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog: cycles in a row in which neither channel moved an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int  roll;
        int  target;
        int  total_cmds;
        bit  draining;
        bit  timed_out;

        // Directed opening: pops from an empty stack, divide by zero on an
        // empty stack (underflow wins), signed wrap on add, the most negative
        // value over minus one, a plain divide by zero, both unused modes, a multiply
        // and a subtract, then a fill to the top and a push onto the full stack.
        add_cmd(MODE_FINISH, '0);
        add_cmd(MODE_DIV, 32'hFFFF_FFFF);
        add_cmd(MODE_ADD, '0);
        add_cmd(MODE_PUSH, 32'h7FFF_FFFF);
        add_cmd(MODE_PUSH, 32'd1);
        add_cmd(MODE_ADD, '0);
        add_cmd(MODE_PUSH, 32'hFFFF_FFFF);
        add_cmd(MODE_DIV, '0);
        add_cmd(MODE_PUSH, '0);
        add_cmd(MODE_DIV, '0);
        add_cmd(3'd6, 32'hAAAA_AAAA);
        add_cmd(3'd7, 32'h5555_5555);
        add_cmd(MODE_PUSH, 32'hFFFF_FFF9);
        add_cmd(MODE_MUL, '0);
        add_cmd(MODE_SUB, '0);
        while (gen_depth < STACK_DEPTH) add_cmd(MODE_PUSH, rand_operand());
        add_cmd(MODE_PUSH, 32'h8000_0000);

        // Random part: mostly well-formed programs that push up to a random
        // depth, reduce with arithmetic down to one entry and finish, with
        // some stray pushes and a little noise of any mode, unused ones too.
        target   = $urandom_range(2, STACK_DEPTH);
        draining = 1'b0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                add_cmd(MODE_W'($urandom_range(0, 7)), $urandom());
            end else if (roll < 7) begin
                add_cmd(MODE_PUSH, rand_operand());
            end else if (!draining && gen_depth < target) begin
                add_cmd(MODE_PUSH, rand_operand());
            end else if (gen_depth > 1) begin
                draining = 1'b1;
                add_cmd(MODE_W'($urandom_range(MODE_ADD, MODE_DIV)), $urandom());
            end else begin
                add_cmd(MODE_FINISH, $urandom());
                draining = 1'b0;
                target   = $urandom_range(2, STACK_DEPTH);
            end
        end
        total_cmds = pending_cmds.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(items_taken == total_cmds && results_seen == total_cmds)
               && quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        timed_out = (quiet_cycles >= QUIET_LIMIT);
        if (timed_out) begin
            errors++;
            $display("%0t: no item moved for %0d cycles, %0d of %0d results in",
                     $time, QUIET_LIMIT, results_seen, total_cmds);
        end else begin
            // Anything arriving now is an extra result and fails the run.
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end
        if (awaited_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
        end

        $display("Ran %0d commands, checked %0d results, deepest stack %0d.",
                 items_taken, results_seen, peak_depth);
        $display("Status seen: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
                 status_hits[STAT_OK], status_hits[STAT_UNDER],
                 status_hits[STAT_OVERFLOW], status_hits[STAT_DIVZERO]);
        if (errors == 0 && !timed_out) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
